/* hdl/sems_pkg.sv */
// Shared types, codes and elaboration-time table builders for the stick expo scaler.
package sems_pkg;

  // Stabilization mode codes
  typedef enum logic [3:0] {
    MODE_MANUAL       = 4'd0,
    MODE_RATE         = 4'd1,
    MODE_WEAKLEVELING = 4'd2,
    MODE_ATTITUDE     = 4'd3,
    MODE_AXISLOCK     = 4'd4,
    MODE_VIRTUALBAR   = 4'd5,
    MODE_ACRO         = 4'd6,
    MODE_RATTITUDE    = 4'd7,
    MODE_ALTVARIO     = 4'd8
  } mode_e;

  // Register indexes
  localparam logic [2:0] REG_EXPO_ROLL  = 3'd0;
  localparam logic [2:0] REG_EXPO_PITCH = 3'd1;
  localparam logic [2:0] REG_EXPO_YAW   = 3'd2;
  localparam logic [2:0] REG_RATE_ROLL  = 3'd3;
  localparam logic [2:0] REG_RATE_PITCH = 3'd4;
  localparam logic [2:0] REG_RATE_YAW   = 3'd5;
  localparam logic [2:0] REG_MAX_ANGLES = 3'd6;

  localparam int unsigned RateResetVal = 150;

  // How an axis is scaled after shaping
  typedef enum logic [1:0] {
    SC_PASS,
    SC_RATE,
    SC_ANGLE,
    SC_ZERO
  } scale_e;

  typedef struct packed {
    logic [2:0][7:0]  expo;
    logic [2:0][10:0] rate;
    logic [2:0][7:0]  angle;
  } cfg_t;

  typedef struct packed {
    logic [15:0] stick;
    scale_e      kind;
    logic [10:0] factor;
  } axis_t;

  typedef struct packed {
    axis_t [2:0] ax;
    logic [15:0] thrust;
    logic [3:0]  roll_mode;
    logic [3:0]  pitch_mode;
    logic [3:0]  yaw_mode;
    logic [3:0]  thrust_mode;
  } item_t;

  // log2 of a Q30 value in [1,2), 16 fraction bits, by repeated squaring
  function automatic logic [63:0] lgq(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    x = x_in;
    res = '0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        res = (res << 1) | 64'd1;
      end else begin
        res = res << 1;
      end
    end
    return res;
  endfunction

  // log table entry i of 2^lg entries (Q16)
  function automatic logic [63:0] lt_entry(input int unsigned i, input int unsigned lg);
    logic [63:0] n;
    n = 64'd1 << lg;
    if (64'(i) >= n) return 64'd65536;
    return lgq(((n + 64'(i)) << 30) >> lg);
  endfunction

  // exp2 table entry i of 2^lg entries (Q16)
  function automatic logic [63:0] et_entry(input int unsigned i, input int unsigned lg);
    logic [63:0] n;
    logic [63:0] t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    n = 64'd1 << lg;
    if (64'(i) >= n) return 64'd131072;
    t = (64'(i) << 16) >> lg;
    lo = 64'd65536;
    hi = 64'd131071;
    for (int j = 0; j < 18; j++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (lgq(mid << 14) <= t) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  function automatic logic [63:0] exp_frac(input logic [63:0] g, input int unsigned lg);
    logic [63:0] s;
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] b0;
    logic [63:0] b1;
    s = (g & 64'hFFFF) << lg;
    k = s >> 16;
    r = s & 64'hFFFF;
    b0 = et_entry(int'(k), lg);
    b1 = et_entry(int'(k) + 1, lg);
    return b0 + (((b1 - b0) * r) >> 16);
  endfunction

  // Curve exponent (Q16) for a raw expo register byte
  function automatic logic [17:0] e_of_expo(input logic [7:0] expo, input int unsigned lg);
    int          ex;
    int          t;
    logic [63:0] e;
    logic [63:0] y;
    logic [63:0] sh;
    ex = int'($signed(expo));
    if (ex > 100) ex = 100;
    if (ex < -100) ex = -100;
    t = (ex * 65536) / 100;
    if (t >= 65536) begin
      e = 64'd131072;
    end else if (t >= 0) begin
      e = exp_frac(64'(t), lg);
    end else begin
      y = 64'(-t);
      sh = (y + 64'd65535) >> 16;
      if (sh >= 64'd32) e = 64'd0;
      else e = exp_frac((64'd65536 - (y & 64'hFFFF)) & 64'hFFFF, lg) >> sh;
    end
    if (e < 64'd32768) e = 64'd32768;
    if (e > 64'd131072) e = 64'd131072;
    return e[17:0];
  endfunction

endpackage

/* hdl/stick_expo_mode_scaler.sv */
// Top level: config registers, front classifier, queue and shaping back end.
// Stick expo shaper and mode scaler. Takes one item per cycle while the output is not stalled; an
// accepted item is captured by the front register, waits in the two-entry queue, then passes six
// back stages: log table, log interpolate, exponent multiply, exp table, interpolate and shift,
// scale and saturate into the result register. Throughput is one item per cycle, set by the fully
// pipelined back end; output stalls back up through the queue.
// Rate and angle writes take effect on items accepted after the write; expo writes also reach items
// still ahead of the exponent multiply; write only when idle.
module stick_expo_mode_scaler
  import sems_pkg::*;
#(
  parameter int unsigned LOG_TABLE_ENTRIES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // roll_stick, pitch_stick, yaw_stick, thrust_stick, roll_mode, pitch_mode, yaw_mode,
  // thrust_mode, roam_active, roam_thrust_manual, zero pad
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll_desired, pitch_desired, yaw_desired, thrust_desired, roll_mode_out,
  // pitch_mode_out, yaw_mode_out, thrust_mode_out, zero pad
  output logic [119:0] m_axis_tdata
);

  cfg_t  cfg_q;
  logic  f_vld, q_full, q_empty, q_pop;
  item_t f_item, q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expo  <= '0;
      cfg_q.rate  <= {3{11'(RateResetVal)}};
      cfg_q.angle <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EXPO_ROLL:  cfg_q.expo[0] <= cfg_data_i[7:0];
        REG_EXPO_PITCH: cfg_q.expo[1] <= cfg_data_i[7:0];
        REG_EXPO_YAW:   cfg_q.expo[2] <= cfg_data_i[7:0];
        REG_RATE_ROLL:  cfg_q.rate[0] <= cfg_data_i[10:0];
        REG_RATE_PITCH: cfg_q.rate[1] <= cfg_data_i[10:0];
        REG_RATE_YAW:   cfg_q.rate[2] <= cfg_data_i[10:0];
        REG_MAX_ANGLES: cfg_q.angle   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sems_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (f_vld),
    .out_ready_i (!q_full),
    .out_item_o  (f_item)
  );

  sems_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_vld && !q_full),
    .full_o      (q_full),
    .push_item_i (f_item),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (q_item)
  );

  sems_back #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* hdl/sems_front.sv */
// Front end: takes input items and classifies each axis' mode into a scale kind and factor.
module sems_front
  import sems_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [87:0] in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output item_t       out_item_o
);

  logic  f_vld_q;
  item_t f_q, f_d;

  function automatic axis_t classify(input logic [15:0] stick, input logic [3:0] mode,
                                     input logic [10:0] rate, input logic [7:0] angle);
    axis_t a;
    a.stick = stick;
    a.factor = '0;
    case (mode)
      MODE_MANUAL, MODE_VIRTUALBAR: a.kind = SC_PASS;
      MODE_RATE, MODE_AXISLOCK, MODE_ACRO: begin
        a.kind = SC_RATE;
        a.factor = rate;
      end
      MODE_WEAKLEVELING, MODE_ATTITUDE, MODE_RATTITUDE: begin
        a.kind = SC_ANGLE;
        a.factor = {3'b000, angle};
      end
      default: a.kind = SC_ZERO;
    endcase
    return a;
  endfunction

  // Decode one input item
  always_comb begin
    logic [3:0] ym;
    ym = in_data_i[75:72];
    f_d.ax[0] = classify(in_data_i[15:0], in_data_i[67:64], cfg_i.rate[0], cfg_i.angle[0]);
    f_d.ax[1] = classify(in_data_i[31:16], in_data_i[71:68], cfg_i.rate[1], cfg_i.angle[1]);
    // yaw rattitude runs as rate
    if (ym == MODE_RATTITUDE) ym = MODE_RATE;
    f_d.ax[2] = classify(in_data_i[47:32], ym, cfg_i.rate[2], cfg_i.angle[2]);
    f_d.thrust = in_data_i[63:48];
    f_d.roll_mode = in_data_i[67:64];
    f_d.pitch_mode = in_data_i[71:68];
    f_d.yaw_mode = ym;
    if (in_data_i[80]) f_d.thrust_mode = in_data_i[81] ? MODE_MANUAL : MODE_ALTVARIO;
    else f_d.thrust_mode = in_data_i[79:76];
  end

  assign in_ready_o  = !f_vld_q || out_ready_i;
  assign out_valid_o = f_vld_q;
  assign out_item_o  = f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      f_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      f_q <= f_d;
    end
  end

endmodule

/* hdl/sems_fifo.sv */
// Two-entry queue of classified items between front and back.
module sems_fifo
  import sems_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  item_t push_item_i,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

/* hdl/sems_axis.sv */
// Six-stage pipeline for one axis: log2, multiply by exponent, exp2, then scale and saturate.
module sems_axis
  import sems_pkg::*;
#(
  parameter int unsigned LOG_TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  axis_t       ax_i,
  input  logic [17:0] e_i,
  output logic [26:0] desired_o
);

  localparam int unsigned Lg = $clog2(LOG_TABLE_ENTRIES);

  logic [16:0] lt_tab [LOG_TABLE_ENTRIES + 1];
  logic [17:0] et_tab [LOG_TABLE_ENTRIES + 1];

  for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_tab
    localparam logic [63:0] LtV = lt_entry(gi, Lg);
    localparam logic [63:0] EtV = et_entry(gi, Lg);
    assign lt_tab[gi] = LtV[16:0];
    assign et_tab[gi] = EtV[17:0];
  end

  // sideband taps per stage
  typedef struct packed {
    logic        neg;
    logic        zero;
    logic        full;
    scale_e      kind;
    logic [10:0] factor;
  } side_t;

  side_t       sd_q [1:5];
  side_t       sd0;

  // stage 0: magnitude, normalize, log table read
  logic [15:0] m, norm;
  logic [3:0]  z;
  logic [14:0] q;
  logic [14:0] r0;
  logic [Lg:0] k0;
  logic [16:0] lt0_q, ltd_q;
  logic [14:0] r1_q;
  logic [3:0]  z1_q;

  always_comb begin
    logic [14+Lg:0] s;
    m = ax_i.stick[15] ? 16'(-ax_i.stick) : ax_i.stick;
    z = 4'd15;
    for (int i = 0; i < 15; i++) begin
      if (m[i]) z = 4'(15 - i);
    end
    norm = m << z;
    q = norm[14:0];
    s = {q, {Lg{1'b0}}};
    k0 = {1'b0, s[14+Lg:15]};
    r0 = s[14:0];
    sd0.neg = ax_i.stick[15];
    sd0.zero = ax_i.stick == 16'd0;
    sd0.full = m[15];
    sd0.kind = ax_i.kind;
    sd0.factor = ax_i.factor;
  end

  // stage 1: interpolate log, form -log2 of magnitude
  logic [19:0] lm;
  logic [19:0] lm_q;
  always_comb begin
    logic [31:0] pr;
    logic [20:0] diff;
    pr = ltd_q * r1_q;
    diff = {z1_q, 16'd0} - (21'(lt0_q) + 21'(pr >> 15));
    lm = diff[20] ? 20'd0 : diff[19:0];
  end

  // stage 2: times exponent
  logic [37:0] ey;
  logic [21:0] y_q;
  assign ey = e_i * lm_q;

  // stage 3: split exponent, exp table read
  logic [22:0] ysum;
  logic [15:0] g, r4;
  logic [Lg:0] k4;
  logic [17:0] et0_q, etd_q;
  logic [15:0] r4_q;
  logic [4:0]  sh_q;
  logic        big_q;
  always_comb begin
    logic [15+Lg:0] gs;
    ysum = 23'(y_q) + 23'd65535;
    g = 16'(16'd0 - y_q[15:0]);
    gs = {g, {Lg{1'b0}}};
    k4 = {1'b0, gs[15+Lg:16]};
    r4 = gs[15:0];
  end

  // stage 4: interpolate exp, shift, bound, sign
  logic signed [16:0] shp;
  logic signed [16:0] shp_q;
  always_comb begin
    logic [33:0] pr;
    logic [17:0] x;
    logic [17:0] mag;
    pr = etd_q * r4_q;
    x = et0_q + 18'(pr >> 16);
    mag = big_q ? 18'd0 : ((x >> sh_q) >> 1);
    if (mag > 18'd32768) mag = 18'd32768;
    if (sd_q[4].full) mag = 18'd32768;
    if (sd_q[4].zero) mag = 18'd0;
    shp = sd_q[4].neg ? -$signed({1'b0, mag[15:0]}) : $signed({1'b0, mag[15:0]});
    if (sd_q[4].neg && mag[15]) shp = -17'sd32768;
    else if (!sd_q[4].neg && mag[15]) shp = 17'sd32768 - 17'sd0;
  end

  // stage 5: scale and saturate
  logic signed [28:0] sc;
  logic [26:0] out_q;
  always_comb begin
    case (sd_q[5].kind)
      SC_PASS:          sc = 29'(shp_q);
      SC_RATE, SC_ANGLE: sc = shp_q * $signed({1'b0, sd_q[5].factor});
      default:          sc = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[1] <= sd0;
      for (int i = 2; i <= 5; i++) sd_q[i] <= sd_q[i - 1];
      lt0_q <= lt_tab[k0];
      ltd_q <= lt_tab[k0 + 1'b1] - lt_tab[k0];
      r1_q  <= r0;
      z1_q  <= z;
      lm_q  <= lm;
      y_q   <= ey[37:16];
      et0_q <= et_tab[k4];
      etd_q <= et_tab[k4 + 1'b1] - et_tab[k4];
      r4_q  <= r4;
      sh_q  <= ysum[20:16];
      big_q <= ysum[22:16] >= 7'd32;
      shp_q <= shp;
      if (sc > 29'sd67108863) out_q <= 27'h3FF_FFFF;
      else if (sc < -29'sd67108864) out_q <= 27'h400_0000;
      else out_q <= sc[26:0];
    end
  end

  assign desired_o = out_q;

endmodule

/* hdl/sems_back.sv */
// Back end: pops classified items, runs three axis pipelines and holds the result register.
module sems_back
  import sems_pkg::*;
#(
  parameter int unsigned LOG_TABLE_ENTRIES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         q_empty_i,
  output logic         q_pop_o,
  input  item_t        q_item_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [119:0] out_data_o
);

  localparam int unsigned Lg = $clog2(LOG_TABLE_ENTRIES);
  localparam int unsigned Depth = 6;

  typedef struct packed {
    logic [15:0] thrust;
    logic [3:0]  rm;
    logic [3:0]  pm;
    logic [3:0]  ym;
    logic [3:0]  tm;
  } pass_t;

  // exponent table indexed by the raw expo byte
  logic [17:0] e_tab [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_etab
    localparam logic [17:0] EV = e_of_expo(8'(gi), Lg);
    assign e_tab[gi] = EV;
  end

  logic              en;
  logic [Depth-1:0]  vld_q;
  pass_t             ps_q [Depth];
  logic [2:0][26:0]  des;

  assign en          = !vld_q[Depth-1] || out_ready_i;
  assign q_pop_o     = en && !q_empty_i;
  assign out_valid_o = vld_q[Depth-1];

  for (genvar a = 0; a < 3; a++) begin : g_ax
    sems_axis #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_axis (
      .clk_i     (clk_i),
      .en_i      (en),
      .ax_i      (q_item_i.ax[a]),
      .e_i       (e_tab[cfg_i.expo[a]]),
      .desired_o (des[a])
    );
  end

  // valid and pass-through delay line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], q_pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q[0] <= '{q_item_i.thrust, q_item_i.roll_mode, q_item_i.pitch_mode,
                   q_item_i.yaw_mode, q_item_i.thrust_mode};
      for (int i = 1; i < Depth; i++) ps_q[i] <= ps_q[i - 1];
    end
  end

  assign out_data_o = {7'd0, ps_q[Depth-1].tm, ps_q[Depth-1].ym, ps_q[Depth-1].pm,
                       ps_q[Depth-1].rm, ps_q[Depth-1].thrust, des[2], des[1], des[0]};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

/* test/tb.sv */
// Self-checking testbench for the stick expo shaper and mode scaler.
`timescale 1ns / 100ps

module tb;
  import sems_pkg::*;

  localparam int unsigned NTAB = 256;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [2:0] RegUnused = 3'd7;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [23:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // roll_stick, pitch_stick, yaw_stick, thrust_stick, roll_mode, pitch_mode, yaw_mode,
  // thrust_mode, roam_active, roam_thrust_manual, zero pad
  logic [87:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // roll_desired, pitch_desired, yaw_desired, thrust_desired, roll_mode_out,
  // pitch_mode_out, yaw_mode_out, thrust_mode_out, zero pad
  logic [119:0] m_axis_tdata;

  stick_expo_mode_scaler dut (.*);

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Interpolation tables: log2 mantissa and exp2 fraction, Q16
  longint unsigned log_tab[0:NTAB];
  longint unsigned exp_tab[0:NTAB];

  function automatic longint unsigned log2_q30(longint unsigned x_in);
    longint unsigned x;
    longint unsigned acc;
    x = x_in;
    acc = 0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        acc = (acc << 1) | 1;
      end else begin
        acc = acc << 1;
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned exp_interp(longint unsigned g);
    longint unsigned s;
    longint unsigned k;
    longint unsigned r;
    s = (g & 64'hFFFF) * NTAB;
    k = s >> 16;
    r = s & 64'hFFFF;
    return exp_tab[k] + (((exp_tab[k+1] - exp_tab[k]) * r) >> 16);
  endfunction

  // 2^(-y/65536), Q16
  function automatic longint unsigned exp_down(longint unsigned y);
    longint unsigned sh;
    longint unsigned g;
    sh = (y + 65535) >> 16;
    g = (65536 - (y & 64'hFFFF)) & 64'hFFFF;
    if (sh >= 32) return 0;
    return exp_interp(g) >> sh;
  endfunction

  // sign(v) * |v|^e with the exponent taken from the expo percent
  function automatic longint curve(logic [15:0] stick, logic [7:0] expo);
    longint v;
    longint ex;
    longint t;
    longint lm;
    longint unsigned e;
    longint unsigned m;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned s;
    longint unsigned k;
    longint unsigned r;
    longint unsigned lf;
    int p;
    v = longint'($signed(stick));
    ex = longint'($signed(expo));
    if (v == 0) return 0;
    if (ex > 100) ex = 100;
    if (ex < -100) ex = -100;
    t = (ex * 65536) / 100;
    if (t >= 65536) e = 131072;
    else if (t >= 0) e = exp_interp(longint'(t));
    else e = exp_down(longint'(-t));
    if (e < 32768) e = 32768;
    if (e > 131072) e = 131072;
    m = (v < 0) ? -v : v;
    if (m >= 32768) begin
      mag = 32768;
    end else begin
      p = 14;
      while (p > 0 && m[p] == 1'b0) p--;
      q = (m << (15 - p)) - 32768;
      s = q * NTAB;
      k = s >> 15;
      r = s & 64'h7FFF;
      lf = log_tab[k] + (((log_tab[k+1] - log_tab[k]) * r) >> 15);
      lm = longint'(15 - p) * 65536 - longint'(lf);
      if (lm < 0) lm = 0;
      mag = exp_down((e * longint'(lm)) >> 16) >> 1;
      if (mag > 32768) mag = 32768;
    end
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [26:0] axis_scale(longint s, logic [3:0] mode,
                                             longint rate, longint ang);
    longint r;
    case (mode)
      MODE_MANUAL, MODE_VIRTUALBAR:          r = s;
      MODE_RATE, MODE_AXISLOCK, MODE_ACRO:   r = s * rate;
      MODE_WEAKLEVELING, MODE_ATTITUDE,
      MODE_RATTITUDE:                        r = s * ang;
      default:                               r = 0;
    endcase
    if (r > 67108863) r = 67108863;
    if (r < -67108864) r = -67108864;
    return r[26:0];
  endfunction

  typedef struct packed {
    logic [26:0] roll;
    logic [26:0] pitch;
    logic [26:0] yaw;
    logic [15:0] thrust;
    logic [3:0]  rm;
    logic [3:0]  pm;
    logic [3:0]  ym;
    logic [3:0]  tm;
  } setpoint_t;

  // Setpoint predictor and in-order checker
  class setpoint_board;
    logic [7:0]  expo[3];
    logic [10:0] rate[3];
    logic [23:0] angles;
    setpoint_t   pending[$];
    int          errors;

    function new();
      foreach (expo[i]) expo[i] = 8'd0;
      foreach (rate[i]) rate[i] = 11'(RateResetVal);
      angles = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        REG_EXPO_ROLL:  expo[0] = val[7:0];
        REG_EXPO_PITCH: expo[1] = val[7:0];
        REG_EXPO_YAW:   expo[2] = val[7:0];
        REG_RATE_ROLL:  rate[0] = val[10:0];
        REG_RATE_PITCH: rate[1] = val[10:0];
        REG_RATE_YAW:   rate[2] = val[10:0];
        REG_MAX_ANGLES: angles = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic [87:0] d);
      setpoint_t x;
      logic [3:0] ym;
      longint y;
      x.roll = axis_scale(curve(d[15:0], expo[0]), d[67:64], rate[0], angles[7:0]);
      x.pitch = axis_scale(curve(d[31:16], expo[1]), d[71:68], rate[1], angles[15:8]);
      y = curve(d[47:32], expo[2]);
      ym = d[75:72];
      if (ym == MODE_RATTITUDE) begin
        ym = MODE_RATE;
        x.yaw = axis_scale(y, MODE_RATE, rate[2], 0);
      end else begin
        x.yaw = axis_scale(y, ym, rate[2], angles[23:16]);
      end
      x.thrust = d[63:48];
      x.rm = d[67:64];
      x.pm = d[71:68];
      x.ym = ym;
      x.tm = d[80] ? (d[81] ? MODE_MANUAL : MODE_ALTVARIO) : d[79:76];
      pending.push_back(x);
    endfunction

    function void check_result(logic [119:0] d);
      setpoint_t x;
      if (pending.size() == 0) begin
        $error("result with no item pending: %h", d);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (d[26:0] !== x.roll) begin
        $error("roll_desired exp %0d got %0d", $signed(x.roll), $signed(d[26:0]));
        errors++;
      end
      if (d[53:27] !== x.pitch) begin
        $error("pitch_desired exp %0d got %0d", $signed(x.pitch), $signed(d[53:27]));
        errors++;
      end
      if (d[80:54] !== x.yaw) begin
        $error("yaw_desired exp %0d got %0d", $signed(x.yaw), $signed(d[80:54]));
        errors++;
      end
      if (d[96:81] !== x.thrust) begin
        $error("thrust_desired exp %0d got %0d", $signed(x.thrust), $signed(d[96:81]));
        errors++;
      end
      if (d[100:97] !== x.rm) begin
        $error("roll_mode_out exp %0d got %0d", x.rm, d[100:97]);
        errors++;
      end
      if (d[104:101] !== x.pm) begin
        $error("pitch_mode_out exp %0d got %0d", x.pm, d[104:101]);
        errors++;
      end
      if (d[108:105] !== x.ym) begin
        $error("yaw_mode_out exp %0d got %0d", x.ym, d[108:105]);
        errors++;
      end
      if (d[112:109] !== x.tm) begin
        $error("thrust_mode_out exp %0d got %0d", x.tm, d[112:109]);
        errors++;
      end
    endfunction
  endclass

  setpoint_board board;
  bit quiet;
  bit long_hold_req;
  int unsigned cycles;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** stick_expo_mode_scaler: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : rx_ready
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 17) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Write enable stays high across a run of writes; the caller drops it afterwards
  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  // Wait until the block has drained, plus its pipeline depth
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic send_item(logic [87:0] d);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(d);
  endtask

  function automatic logic [15:0] pick_stick();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = 16'($urandom_range(0, (1 << $urandom_range(0, 14))));
        if ($urandom_range(0, 1)) v = -v;
      end
      1: case ($urandom_range(0, 4))
        0: v = 16'h0000;
        1: v = 16'h7FFF;
        2: v = 16'h8000;
        3: v = 16'h0001;
        default: v = 16'hFFFF;
      endcase
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [3:0] pick_mode();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                       : 4'($urandom_range(0, 8));
  endfunction

  function automatic logic [87:0] make_item(logic [15:0] r, logic [15:0] p, logic [15:0] y,
                                            logic [15:0] t, logic [3:0] rm, logic [3:0] pm,
                                            logic [3:0] ym, logic [3:0] tm, logic ra,
                                            logic rt);
    return {6'd0, rt, ra, tm, ym, pm, rm, t, p, y[15:0], r} & 88'hFF_FFFF_FFFF_FFFF_FFFF_FFFF
           | 88'd0;
  endfunction

  initial begin : stim
    logic [15:0] edge_sticks[5];
    logic [23:0] cfgv[7];
    board = new();
    quiet = 0;
    long_hold_req = 0;
    cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    edge_sticks = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};

    // ROM contents
    for (int i = 0; i < NTAB; i++) begin
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned tq;
      tq = (longint'(i) << 16) / NTAB;
      log_tab[i] = log2_q30(((NTAB + longint'(i)) << 30) / NTAB);
      lo = 65536;
      hi = 131071;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (log2_q30(mid << 14) <= tq) lo = mid;
        else hi = mid - 1;
      end
      exp_tab[i] = lo;
    end
    log_tab[NTAB] = 65536;
    exp_tab[NTAB] = 131072;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at reset settings: edges, every mode, roam overrides
    for (int i = 0; i < 16; i++)
      send_item(make_item(edge_sticks[i % 5], edge_sticks[(i + 1) % 5],
                          edge_sticks[(i + 2) % 5], edge_sticks[(i + 3) % 5],
                          4'(i), 4'(15 - i), 4'(i), 4'(i), i[1], i[2]));
    send_item(make_item(16'h7FFF, 16'h8000, 16'h4000, 16'h8000, MODE_RATE, MODE_ATTITUDE,
                        MODE_RATTITUDE, MODE_ATTITUDE, 1'b1, 1'b1));
    send_item(make_item(16'h0002, 16'hFFFE, 16'hC000, 16'h7FFF, MODE_ACRO, MODE_AXISLOCK,
                        MODE_RATTITUDE, MODE_RATE, 1'b1, 1'b0));
    drain();

    // Phases: extremes first, then random settings
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: cfgv = '{24'd100, 24'd100, 24'd100, 24'd2047, 24'd2047, 24'd2047, 24'hFFFFFF};
        1: cfgv = '{24'hFFFF9C, 24'h9C, 24'h9C, 24'd0, 24'd0, 24'd0, 24'd0};
        2: cfgv = '{24'h7F, 24'h80, 24'hAA55FF, 24'h7FF, 24'd1, 24'hFFF800, 24'h7F80FF};
        default: for (int i = 0; i < 7; i++) cfgv[i] = 24'($urandom);
      endcase
      if (ph > 2 && $urandom_range(0, 1))
        for (int i = 0; i < 3; i++) cfgv[i] = 24'($urandom_range(0, 200) - 100);
      for (int i = 0; i < 7; i++) cfg_write(3'(i), cfgv[i]);
      cfg_write(RegUnused, 24'($urandom));
      cfg_we_i <= 1'b0;
      if (ph == 8) quiet = 1;
      for (int n = 0; n < 190; n++) begin
        if (ph == 4 && n == 20) long_hold_req = 1;
        send_item(make_item(pick_stick(), pick_stick(), pick_stick(), 16'($urandom),
                            pick_mode(), pick_mode(), pick_mode(), 4'($urandom),
                            1'($urandom), 1'($urandom)));
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** stick_expo_mode_scaler: PASSED **");
    end else begin
      $display("** stick_expo_mode_scaler: FAILED **");
    end
    $finish;
  end

endmodule
